FILE: src/isotp_pkg.sv
package isotp_pkg;

  // Result kinds, carried on the result channel's tuser
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FLOW  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SF_LENGTH  = 2'd0,
    ERR_START_TYPE = 2'd1,
    ERR_NOT_CF     = 2'd2
  } err_t;

  // Frame types, high nibble of the protocol control byte
  localparam logic [3:0] TYPE_SF = 4'h0;
  localparam logic [3:0] TYPE_FF = 4'h1;
  localparam logic [3:0] TYPE_CF = 4'h2;

  localparam logic [3:0]  SF_MAX_LEN = 4'd7;
  localparam logic [2:0]  FF_BYTES   = 3'd6;
  localparam logic [2:0]  CF_BYTES   = 3'd7;

  // Register indexes on the configuration port
  localparam logic REG_REQUEST_ID = 1'b0;
  localparam logic [10:0] REQUEST_ID_RESET = 11'h7E0;

  // One frame's worth of work for the emitter: an optional flow-control
  // request, up to seven payload bytes, and an optional closing result.
  typedef struct packed {
    logic            flow;
    logic [2:0]      count;
    logic [7:0][7:0] bytes;
    logic            tail;
    kind_t           tail_kind;
    logic [11:0]     length;
    err_t            err;
    logic [2:0]      last_idx;
  } job_t;

endpackage

FILE: src/isotp_front.sv
module isotp_front import isotp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [10:0]     request_id,
  input  logic            accept,
  input  logic [10:0]     can_id,
  input  logic            is_echo,
  input  logic [7:0][7:0] frame,
  output logic            push,
  output job_t            job
);

  logic        receiving;
  logic        receiving_next;
  logic [11:0] bytes_remaining;
  logic [11:0] bytes_remaining_next;
  logic [11:0] message_total;
  logic [11:0] message_total_next;

  always_comb begin
    logic [3:0]  ftype;
    logic [3:0]  sf_len;
    logic [11:0] ff_total;
    logic [11:0] rem_after;
    logic [3:0]  n_results;

    ftype     = frame[0][7:4];
    sf_len    = frame[0][3:0];
    ff_total  = {frame[0][3:0], frame[1]};
    rem_after = '0;

    push = accept && !is_echo && (can_id == request_id);

    job                  = '0;
    receiving_next       = receiving;
    bytes_remaining_next = bytes_remaining;
    message_total_next   = message_total;

    if (!receiving) begin
      if (ftype == TYPE_SF) begin
        if (sf_len == 4'd0 || sf_len > SF_MAX_LEN) begin
          job.tail      = 1'b1;
          job.tail_kind = KIND_ERROR;
          job.err       = ERR_SF_LENGTH;
        end else begin
          job.count = sf_len[2:0];
          for (int i = 0; i < 7; i++) job.bytes[i] = frame[i + 1];
          job.tail      = 1'b1;
          job.tail_kind = KIND_DONE;
          job.length    = {8'd0, sf_len};
        end
      end else if (ftype == TYPE_FF) begin
        job.flow  = 1'b1;
        job.count = (ff_total < {9'd0, FF_BYTES}) ? ff_total[2:0] : FF_BYTES;
        for (int i = 0; i < 6; i++) job.bytes[i] = frame[i + 2];
        message_total_next = ff_total;
        if (ff_total <= {9'd0, FF_BYTES}) begin
          job.tail             = 1'b1;
          job.tail_kind        = KIND_DONE;
          job.length           = ff_total;
          bytes_remaining_next = '0;
        end else begin
          bytes_remaining_next = ff_total - {9'd0, FF_BYTES};
          receiving_next       = 1'b1;
        end
      end else begin
        job.tail      = 1'b1;
        job.tail_kind = KIND_ERROR;
        job.err       = ERR_START_TYPE;
      end
    end else begin
      if (ftype != TYPE_CF) begin
        job.tail             = 1'b1;
        job.tail_kind        = KIND_ERROR;
        job.err              = ERR_NOT_CF;
        receiving_next       = 1'b0;
        bytes_remaining_next = '0;
      end else begin
        // Sequence nibble is not checked; drop bytes past the message end
        job.count = (bytes_remaining < {9'd0, CF_BYTES}) ? bytes_remaining[2:0]
                                                          : CF_BYTES;
        for (int i = 0; i < 7; i++) job.bytes[i] = frame[i + 1];
        rem_after            = bytes_remaining - {9'd0, job.count};
        bytes_remaining_next = rem_after;
        if (rem_after == 12'd0) begin
          job.tail       = 1'b1;
          job.tail_kind  = KIND_DONE;
          job.length     = message_total;
          receiving_next = 1'b0;
        end
      end
    end

    n_results    = {3'd0, job.flow} + {1'b0, job.count} + {3'd0, job.tail};
    job.last_idx = 3'(n_results - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving       <= 1'b0;
      bytes_remaining <= '0;
      message_total   <= '0;
    end else if (push) begin
      receiving       <= receiving_next;
      bytes_remaining <= bytes_remaining_next;
      message_total   <= message_total_next;
    end
  end

endmodule

FILE: src/isotp_queue.sv
module isotp_queue import isotp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  output logic head_valid,
  output job_t head,
  input  logic pop
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: src/isotp_back.sv
module isotp_back import isotp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  job_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output kind_t       out_kind,
  output logic [7:0]  out_byte,
  output logic [11:0] out_length,
  output err_t        out_err,
  output logic        out_last
);

  logic [2:0]  idx;
  logic        advance;
  logic [2:0]  pos;
  kind_t       kind_next;
  logic [7:0]  byte_next;
  logic [11:0] length_next;
  err_t        err_next;

  assign advance = head_valid && (!out_valid || out_ready);
  assign pop     = advance && (idx == head.last_idx);
  assign pos     = idx - {2'd0, head.flow};

  // Walk the job: flow-control request first, then bytes, then the tail
  always_comb begin
    kind_next   = KIND_BYTE;
    byte_next   = '0;
    length_next = '0;
    err_next    = ERR_SF_LENGTH;
    if (head.flow && idx == 3'd0) begin
      kind_next = KIND_FLOW;
    end else if (pos < head.count) begin
      byte_next = head.bytes[pos];
    end else begin
      kind_next   = head.tail_kind;
      length_next = head.length;
      err_next    = head.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        idx       <= pop ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind   <= kind_next;
      out_byte   <= byte_next;
      out_length <= length_next;
      out_err    <= err_next;
      out_last   <= (idx == head.last_idx);
    end
  end

endmodule

FILE: src/isotp_receive_reassembler_unit.sv
// ISO-TP receive reassembler for classic 8-byte CAN frames.
// Input channel (s_*): one received frame per item. s_tdata carries the
// identifier and the eight frame bytes, s_tuser flags an own transmit echo.
// Echoed frames and frames off the request identifier are taken and dropped.
// Output channel (m_*): one result per item - payload byte, flow-control
// request, message done with its length, or error with a code. m_tlast
// marks the last result caused by one frame.
// APB port: register 0 at byte address 0 holds the request identifier.
// Each accepted frame is classified into a 2-entry job queue, and its
// results then pass through the emitter register.
// Throughput: the emitter gives one result per cycle while m_tready allows,
// and a frame yields 1 to 8 results; frames are accepted back to back
// while the job queue has room.
// Reset clears the reassembly state, the queue and the output valid flag and
// loads request identifier 0x7E0. When the receiver stalls, the output
// register holds its result, the emitter waits, the queue fills and then
// s_tready drops until a job slot frees.
module isotp_receive_reassembler_unit import isotp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // can_id[10:0], frame_byte0..frame_byte7, zero pad
  input  logic [0:0]  s_tuser,   // is_echo
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // data_byte[7:0], message_length[19:8],
                                 // error_code[21:20], zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,   // end_of_run
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0]     request_id;
  logic [7:0][7:0] frame;
  logic            accept;
  logic            push;
  job_t            job;
  logic            full;
  logic            head_valid;
  job_t            head;
  logic            pop;
  kind_t           out_kind;
  logic [7:0]      out_byte;
  logic [11:0]     out_length;
  err_t            out_err;

  // Configuration: writes land on the access cycle, reads are immediate
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REQUEST_ID) ? {21'd0, request_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_id <= REQUEST_ID_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_REQUEST_ID) begin
      request_id <= pwdata[10:0];
    end
  end

  // Unpack the frame bytes
  always_comb begin
    for (int i = 0; i < 8; i++) frame[i] = s_tdata[11 + 8*i +: 8];
  end

  // Take a frame whenever a job slot is free; ignored frames push nothing
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  isotp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request_id (request_id),
    .accept     (accept),
    .can_id     (s_tdata[10:0]),
    .is_echo    (s_tuser[0]),
    .frame      (frame),
    .push       (push),
    .job        (job)
  );

  isotp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  isotp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_length (out_length),
    .out_err    (out_err),
    .out_last   (m_tlast)
  );

  // Pack the result item
  assign m_tdata = {2'd0, out_err, out_length, out_byte};
  assign m_tuser = out_kind;

endmodule

FILE: test/isotp_receive_reassembler_unit_tb.sv
// Frame-level check of the ISO-TP receive reassembler.
// A table of directed frames runs first, then five phases of random traffic,
// each under its own request identifier. Every accepted frame is run through
// a local reassembly predictor; the result items it produces are queued and
// matched in order against the result channel.
module isotp_receive_reassembler_unit_tb;
  import isotp_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 16;    // pipeline depth plus margin
  localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
  localparam int NUM_PHASES    = 5;
  localparam int PHASE_FRAMES  = 60;
  localparam int MAX_REPORTS   = 10;

  // error_code reads zero on every result that is not an error
  localparam err_t NO_ERROR = ERR_SF_LENGTH;

  typedef enum logic [1:0] {
    CHECK_PREDICT,  // expectation comes from the predictor
    CHECK_NONE,     // frame must be dropped without a result
    CHECK_ONE       // exactly one typed result
  } check_t;

  typedef struct packed {
    logic [10:0]     can_id;
    logic            is_echo;
    logic [7:0][7:0] fb;      // fb[0] is the protocol control byte
  } can_frame_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [11:0] length;
    err_t        err;
    logic        last;
  } result_t;

  typedef struct packed {
    can_frame_t frame;
    check_t     mode;
    kind_t      kind;
    err_t       err;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // can_id[10:0], frame_byte0..frame_byte7, zero pad
  logic [0:0]  s_tuser;   // is_echo
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // data_byte[7:0], message_length[19:8], error_code[21:20]
  logic [1:0]  m_tuser;   // kind
  logic        m_tlast;   // end_of_run
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  isotp_receive_reassembler_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor copy of the block's state and its one register
  logic [10:0] cfg_request_id;
  logic        rx_active;
  logic [11:0] rx_remaining;
  logic [11:0] rx_total;

  result_t   frame_results[$];   // results of the frame just accepted
  result_t   due_results[$];     // results still owed by the block
  stim_row_t directed_rows[$];

  int  mismatch_count;
  int  frames_counted;           // frames the block acts on, ignored ones excluded
  bit  hold_request;             // ask the receiver for one long hold-off
  bit  steady_flow;              // no idling on either side

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs
  initial begin
    int cycle_count;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, due_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic void count_mismatch(string detail);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch: %s", detail);
  endfunction

  function automatic void add_result(kind_t kind, logic [7:0] data_byte,
                                     logic [11:0] length, err_t err);
    result_t r;
    r.kind      = kind;
    r.data_byte = data_byte;
    r.length    = length;
    r.err       = err;
    r.last      = 1'b0;
    frame_results.push_back(r);
  endfunction

  // Work out the results one frame causes and advance the reassembly state
  function automatic void reassemble_frame(can_frame_t f);
    logic [3:0]  ftype;
    logic [3:0]  sf_len;
    logic [11:0] total;
    logic [11:0] take;
    result_t     r;
    int          i;
    frame_results.delete();
    if (f.is_echo || f.can_id != cfg_request_id)
      return;
    ftype  = f.fb[0][7:4];
    sf_len = f.fb[0][3:0];
    if (!rx_active) begin
      if (ftype == TYPE_SF) begin
        if (sf_len == 4'd0 || sf_len > SF_MAX_LEN) begin
          add_result(KIND_ERROR, 8'd0, 12'd0, ERR_SF_LENGTH);
        end else begin
          for (i = 1; i <= sf_len; i++)
            add_result(KIND_BYTE, f.fb[i], 12'd0, NO_ERROR);
          add_result(KIND_DONE, 8'd0, {8'd0, sf_len}, NO_ERROR);
        end
      end else if (ftype == TYPE_FF) begin
        total = {sf_len, f.fb[1]};
        take  = (total < FF_BYTES) ? total : 12'(FF_BYTES);
        add_result(KIND_FLOW, 8'd0, 12'd0, NO_ERROR);
        for (i = 0; i < take; i++)
          add_result(KIND_BYTE, f.fb[2 + i], 12'd0, NO_ERROR);
        rx_total = total;
        if (total <= FF_BYTES) begin
          add_result(KIND_DONE, 8'd0, total, NO_ERROR);
          rx_remaining = 12'd0;
        end else begin
          rx_remaining = total - FF_BYTES;
          rx_active    = 1'b1;
        end
      end else begin
        add_result(KIND_ERROR, 8'd0, 12'd0, ERR_START_TYPE);
      end
    end else if (ftype != TYPE_CF) begin
      // anything but a consecutive frame aborts the message
      add_result(KIND_ERROR, 8'd0, 12'd0, ERR_NOT_CF);
      rx_active    = 1'b0;
      rx_remaining = 12'd0;
    end else begin
      // sequence nibble is not checked; bytes past the message end are dropped
      take = (rx_remaining < CF_BYTES) ? rx_remaining : 12'(CF_BYTES);
      for (i = 0; i < take; i++)
        add_result(KIND_BYTE, f.fb[1 + i], 12'd0, NO_ERROR);
      rx_remaining = rx_remaining - take;
      if (rx_remaining == 12'd0) begin
        add_result(KIND_DONE, 8'd0, rx_total, NO_ERROR);
        rx_active = 1'b0;
      end
    end
    if (frame_results.size() > 0) begin
      r = frame_results.pop_back();
      r.last = 1'b1;
      frame_results.push_back(r);
    end
  endfunction

  // Offer one frame after a random gap, hold it until taken, then predict
  task automatic send_frame(can_frame_t f, check_t mode, result_t typed);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, f.fb, f.can_id};
    s_tuser  <= f.is_echo;
    do @(posedge clk); while (!s_tready);
    if (!f.is_echo && f.can_id == cfg_request_id)
      frames_counted++;
    reassemble_frame(f);
    case (mode)
      CHECK_PREDICT: foreach (frame_results[i]) due_results.push_back(frame_results[i]);
      CHECK_ONE:     due_results.push_back(typed);
      default: ;
    endcase
  endtask

  // Drop valid and wait until the block has delivered everything it owes
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_request_id(logic [10:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_REQUEST_ID, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {21'd0, want})
      count_mismatch($sformatf("request_id read %h, expected %h", prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the request identifier, read it back, update the predictor
  task automatic set_request_id(logic [10:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_REQUEST_ID, 2'b00};
    pwdata  <= {21'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // the read-back setup cycle follows the write access cycle directly
    cfg_request_id = value;
    check_request_id(value);
  endtask

  function automatic can_frame_t make_frame(logic [10:0] id, logic echo, logic [7:0] pci);
    can_frame_t f;
    int i;
    f.can_id  = id;
    f.is_echo = echo;
    for (i = 1; i < 8; i++)
      f.fb[i] = 8'($urandom_range(0, 255));
    f.fb[0] = pci;
    return f;
  endfunction

  // A frame the block must drop: own echo, or another identifier
  function automatic can_frame_t make_ignored_frame();
    if ($urandom_range(0, 1))
      return make_frame(11'($urandom_range(0, 2047)), 1'b1, 8'($urandom_range(0, 255)));
    return make_frame(cfg_request_id ^ 11'($urandom_range(1, 2047)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endfunction

  // First frame plus its consecutive frames, with ignored frames mixed in;
  // long messages and a few short ones are broken off by a wrong frame type
  task automatic send_message();
    logic [11:0] total;
    logic [3:0]  wrong_type;
    int          cf_frames;
    int          abort_at;
    int          k;
    can_frame_t  f;
    if ($urandom_range(0, 99) < 88)
      total = 12'($urandom_range(7, 48));
    else if ($urandom_range(0, 3) == 0)
      total = 12'($urandom_range(256, 4095));
    else
      total = 12'($urandom_range(49, 255));
    f = make_frame(cfg_request_id, 1'b0, {TYPE_FF, total[11:8]});
    f.fb[1] = total[7:0];
    send_frame(f, CHECK_PREDICT, '0);
    cf_frames = (int'(total) - FF_BYTES + CF_BYTES - 1) / CF_BYTES;
    if (total > 12'd255)
      abort_at = $urandom_range(2, 8);
    else if ($urandom_range(0, 19) == 0)
      abort_at = $urandom_range(0, cf_frames - 1);
    else
      abort_at = cf_frames;
    for (k = 0; k < cf_frames; k++) begin
      if (k == abort_at) begin
        wrong_type = 4'($urandom_range(0, 14));
        if (wrong_type >= TYPE_CF)
          wrong_type = wrong_type + 4'd1;
        send_frame(make_frame(cfg_request_id, 1'b0, {wrong_type, 4'($urandom_range(0, 15))}),
                   CHECK_PREDICT, '0);
        return;
      end
      if ($urandom_range(0, 9) == 0)
        send_frame(make_ignored_frame(), CHECK_PREDICT, '0);
      send_frame(make_frame(cfg_request_id, 1'b0, {TYPE_CF, 4'($urandom_range(0, 15))}),
                 CHECK_PREDICT, '0);
    end
  endtask

  task automatic send_random_traffic(int frame_count);
    int         target;
    int         pick;
    can_frame_t f;
    target = frames_counted + frame_count;
    while (frames_counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_frame(make_frame(cfg_request_id, 1'b0, {TYPE_SF, 4'($urandom_range(1, 7))}),
                   CHECK_PREDICT, '0);
      end else if (pick < 70) begin
        send_message();
      end else if (pick < 80) begin
        // first frame that completes the message on its own
        f = make_frame(cfg_request_id, 1'b0, {TYPE_FF, 4'h0});
        f.fb[1] = 8'($urandom_range(0, 6));
        send_frame(f, CHECK_PREDICT, '0);
      end else if (pick < 90) begin
        send_frame(make_ignored_frame(), CHECK_PREDICT, '0);
      end else begin
        // noise on the request identifier: any control byte at all
        send_frame(make_frame(cfg_request_id, 1'b0, 8'($urandom_range(0, 255))),
                   CHECK_PREDICT, '0);
      end
    end
  endtask

  function automatic void add_row(logic [10:0] id, logic echo, logic [7:0] pci,
                                  logic [55:0] payload, check_t mode, kind_t kind, err_t err);
    stim_row_t row;
    int i;
    row.frame.can_id  = id;
    row.frame.is_echo = echo;
    row.frame.fb[0]   = pci;
    // payload lists frame_byte1 first, in the top bits
    for (i = 1; i < 8; i++)
      row.frame.fb[i] = payload[8 * (7 - i) +: 8];
    row.mode = mode;
    row.kind = kind;
    row.err  = err;
    directed_rows.push_back(row);
  endfunction

  // Receiver: random stalls per item, one long hold-off on request
  initial begin
    result_t got;
    result_t want;
    int      stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.kind      = kind_t'(m_tuser);
      got.data_byte = m_tdata[7:0];
      got.length    = m_tdata[19:8];
      got.err       = err_t'(m_tdata[21:20]);
      got.last      = m_tlast;
      if (due_results.size() == 0) begin
        count_mismatch($sformatf("unexpected result kind %0d byte %h len %0d err %0d last %b",
                                 got.kind, got.data_byte, got.length, got.err, got.last));
      end else begin
        want = due_results.pop_front();
        if (got !== want)
          count_mismatch($sformatf({"expected kind %0d byte %h len %0d err %0d last %b, ",
                                    "got kind %0d byte %h len %0d err %0d last %b"},
                                   want.kind, want.data_byte, want.length, want.err, want.last,
                                   got.kind, got.data_byte, got.length, got.err, got.last));
      end
    end
  end

  // Sender and sequencing
  initial begin
    stim_row_t   row;
    result_t     typed;
    logic [10:0] phase_id;
    int          phase;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    cfg_request_id = REQUEST_ID_RESET;
    rx_active      = 1'b0;
    rx_remaining   = 12'd0;
    rx_total       = 12'd0;
    mismatch_count = 0;
    frames_counted = 0;
    hold_request   = 1'b0;
    steady_flow    = 1'b0;

    // idle consecutive frame straight after reset: error, and proves the reset id
    add_row(REQUEST_ID_RESET, 1'b0, 8'h20, 56'hFFFFFFFFFFFFFF, CHECK_ONE, KIND_ERROR, ERR_START_TYPE);
    // dropped frames: echo, neighbor id, top id with echo
    add_row(REQUEST_ID_RESET, 1'b1, 8'h03, 56'h11223344556677, CHECK_NONE, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET + 11'd1, 1'b0, 8'h03, 56'h11223344556677, CHECK_NONE,
            KIND_BYTE, NO_ERROR);
    add_row(11'h7FF, 1'b1, 8'h01, 56'h00000000000000, CHECK_NONE, KIND_BYTE, NO_ERROR);
    // single frame length zero, just over seven, largest nibble
    add_row(REQUEST_ID_RESET, 1'b0, 8'h00, 56'h00000000000000, CHECK_ONE, KIND_ERROR, ERR_SF_LENGTH);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h08, 56'hFFFFFFFFFFFFFF, CHECK_ONE, KIND_ERROR, ERR_SF_LENGTH);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h0F, 56'hFFFFFFFFFFFFFF, CHECK_ONE, KIND_ERROR, ERR_SF_LENGTH);
    // idle, neither single nor first frame
    add_row(REQUEST_ID_RESET, 1'b0, 8'hF5, 56'h00000000000000, CHECK_ONE, KIND_ERROR, ERR_START_TYPE);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h30, 56'h00000000000000, CHECK_ONE, KIND_ERROR, ERR_START_TYPE);
    // single frames, shortest and longest
    add_row(REQUEST_ID_RESET, 1'b0, 8'h01, 56'hFFFFFFFFFFFFFF, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h07, 56'hAA55AA55AA55AA, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    // first frames that complete at once: total zero and six
    add_row(REQUEST_ID_RESET, 1'b0, 8'h10, 56'h00FFFFFFFFFFFF, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h10, 56'h06010203040506, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    // total seven: one byte left for a consecutive frame, rest dropped
    add_row(REQUEST_ID_RESET, 1'b0, 8'h10, 56'h07A1A2A3A4A5A6, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h21, 56'hB1FFFFFFFFFFFF, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    // total twenty over two full consecutive frames, with a dropped frame between
    add_row(REQUEST_ID_RESET, 1'b0, 8'h10, 56'h14001122334455, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h2F, 56'h66778899AABBCC, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b1, 8'h21, 56'h00000000000000, CHECK_NONE, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h20, 56'h0123456789ABCD, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    // largest total, cut short by a single frame
    add_row(REQUEST_ID_RESET, 1'b0, 8'h1F, 56'hFF55AA55AA55AA, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h2A, 56'hFEDCBA98765432, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h03, 56'h11223344556677, CHECK_ONE, KIND_ERROR, ERR_NOT_CF);
    // a new first frame while receiving aborts as well
    add_row(REQUEST_ID_RESET, 1'b0, 8'h10, 56'h08C1C2C3C4C5C6, CHECK_PREDICT, KIND_BYTE, NO_ERROR);
    add_row(REQUEST_ID_RESET, 1'b0, 8'h1A, 56'h00000000000000, CHECK_ONE, KIND_ERROR, ERR_NOT_CF);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_request_id(REQUEST_ID_RESET);

    foreach (directed_rows[r]) begin
      row   = directed_rows[r];
      typed = '0;
      typed.kind = row.kind;
      typed.err  = row.err;
      typed.last = 1'b1;
      send_frame(row.frame, row.mode, typed);
    end

    // Random phases: identifier extremes, reset value and random ones.
    // Phase two starts with a long receiver hold-off so the block backs up;
    // phase three runs without idling on either side.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       phase_id = 11'h000;
        1:       phase_id = 11'h7FF;
        3:       phase_id = REQUEST_ID_RESET;
        default: phase_id = 11'($urandom_range(0, 2047));
      endcase
      set_request_id(phase_id);
      steady_flow  = (phase == 3);
      hold_request = (phase == 2);
      send_random_traffic(PHASE_FRAMES);
    end
    steady_flow = 1'b0;
    drain_results();

    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
